// ----- sv/prtd_pkg.sv -----
// prtd_pkg: shared types and constants for the palette run-length texture decoder
// no dependencies; imported by every module of the block but prtd_ram

package prtd_pkg;

	localparam int PALETTE_DEPTH_DEF = 128;
	localparam int PIXEL_W           = 21;
	localparam int RUN_W             = 8;
	localparam int COLOR_W           = 32;
	localparam int CFG_INDEX_W       = 1;

	// input item modes
	localparam logic MODE_PALETTE = 1'b0;
	localparam logic MODE_CODE    = 1'b1;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_PIXELS = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_OPAQUE_ALPHA = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [6:0]        palette_slot;
		logic [31:0]       palette_color;
		logic signed [7:0] code_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       alpha;
		logic [RUN_W-1:0] run_length;
		logic             image_done;
	} out_item_t;

	// control carried with a code byte from the front stage to the back stage
	typedef struct packed {
		logic [RUN_W-1:0] run;
		logic             index_ok;
	} front_ctl_t;

endpackage

// ----- sv/palette_rle_texture_decoder.sv -----
// palette_rle_texture_decoder: top level, configuration registers, palette RAM, stages
// depends on prtd_pkg, prtd_ram, prtd_front, prtd_back
//
// channel   signals                                  transaction moves
// item      item_valid / item_ready / item           palette write or one code byte
// pixel     pixel_valid / pixel_ready / pixel        one rgba run
// cfg       cfg_valid / cfg_ready / cfg_index, data  one register write
//
// one item per cycle unless the pixel channel stalls; a code byte's run passes through stage one,
// with the registered palette read, and then the result register
// reset clears the armed run, the pixel count and both valid flags; the palette is
// left as it is and must be written before use
// a stalled pixel channel holds the result register, then stage one, then item_ready

module palette_rle_texture_decoder #(
	parameter int PALETTE_DEPTH = prtd_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  prtd_pkg::in_item_t               item,
	output logic                             pixel_valid,
	input  logic                             pixel_ready,
	output prtd_pkg::out_item_t              pixel,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [prtd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [prtd_pkg::PIXEL_W-1:0]     cfg_data
);

	import prtd_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);

	logic [PIXEL_W-1:0] image_pixels_q;
	logic               opaque_alpha_q;

	// palette ram ports
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [COLOR_W-1:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [COLOR_W-1:0] rd_data;

	// stage one between front and back
	logic               valid_s1;
	front_ctl_t         ctl_s1;
	logic               take;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_pixels_q <= PIXEL_W'(1);
			opaque_alpha_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_PIXELS: image_pixels_q <= cfg_data;
				REG_OPAQUE_ALPHA: opaque_alpha_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// palette writes and reads are both issued at the item transaction, so a
	// code byte always sees every palette write accepted before it
	prtd_front #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.take      (take),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.valid_s1  (valid_s1),
		.ctl_s1    (ctl_s1)
	);

	// read data holds while stage one is stalled, as no read is issued then
	prtd_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	prtd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.ctl_s1      (ctl_s1),
		.rd_data     (rd_data),
		.image_pixels(image_pixels_q),
		.opaque_alpha(opaque_alpha_q),
		.take        (take),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel)
	);

	// input only backs up when both stages are full and the output is stalled
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (valid_s1 && pixel_valid && !pixel_ready))
		else $error("item_ready low without a full, stalled pipeline");

	// a run never leaves with zero pixels or more than an armed run allows
	a_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> (pixel.run_length != 8'd0 && pixel.run_length <= 8'd129))
		else $error("run length out of range");

	// a run loaded while opaque mode is set carries full alpha
	a_opaque_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && take && opaque_alpha_q) |=> (pixel.alpha == 8'hff))
		else $error("alpha not forced in opaque mode");

endmodule

// ----- sv/prtd_ram.sv -----
// prtd_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module prtd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- sv/prtd_front.sv -----
// prtd_front: input stage, palette write scaling, run arming and palette read issue
// depends on prtd_pkg

module prtd_front #(
	parameter int PALETTE_DEPTH = prtd_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  prtd_pkg::in_item_t               item,
	input  logic                             take,
	output logic                             wr_en,
	output logic [$clog2(PALETTE_DEPTH)-1:0] wr_addr,
	output logic [prtd_pkg::COLOR_W-1:0]     wr_data,
	output logic                             rd_en,
	output logic [$clog2(PALETTE_DEPTH)-1:0] rd_addr,
	output logic                             valid_s1,
	output prtd_pkg::front_ctl_t             ctl_s1
);

	import prtd_pkg::*;

	localparam int         AW      = $clog2(PALETTE_DEPTH);
	localparam logic [7:0] DEPTH_B = 8'(PALETTE_DEPTH);

	logic             armed_q;
	logic [RUN_W-1:0] armed_run_q;
	logic             accept;
	logic             is_code;
	logic             arm;
	logic             emit;
	logic [7:0]       byte_u;

	// rgb channel c becomes (c * 255) >> 8, which is c - 1 for any non-zero c
	function automatic logic [7:0] scale_channel(input logic [7:0] c);
		return (c == 8'd0) ? 8'd0 : c - 8'd1;
	endfunction

	assign byte_u     = $unsigned(item.code_byte);
	assign item_ready = !valid_s1 || take;
	assign accept     = item_valid && item_ready;
	assign is_code    = (item.mode == MODE_CODE);
	assign arm        = is_code && !armed_q && byte_u[7];
	assign emit       = is_code && !arm;

	assign wr_en   = accept && (item.mode == MODE_PALETTE) && ({1'b0, item.palette_slot} < DEPTH_B);
	assign wr_addr = item.palette_slot[AW-1:0];
	assign wr_data = {item.palette_color[31:24],
	                  scale_channel(item.palette_color[23:16]),
	                  scale_channel(item.palette_color[15:8]),
	                  scale_channel(item.palette_color[7:0])};

	assign rd_en   = accept && emit;
	assign rd_addr = byte_u[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			armed_run_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (accept && is_code) begin
				if (arm) begin
					armed_q     <= 1'b1;
					armed_run_q <= 8'(8'd0 - byte_u);
				end else begin
					armed_q     <= 1'b0;
					armed_run_q <= '0;
				end
			end
			if (accept) begin
				valid_s1 <= emit;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// payload of stage one, no reset needed
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			ctl_s1.run      <= armed_q ? armed_run_q + 8'd1 : 8'd1;
			ctl_s1.index_ok <= (byte_u < DEPTH_B);
		end
	end

endmodule

// ----- sv/prtd_back.sv -----
// prtd_back: run clamping against the image end, pixel count and result register
// depends on prtd_pkg

module prtd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_s1,
	input  prtd_pkg::front_ctl_t         ctl_s1,
	input  logic [prtd_pkg::COLOR_W-1:0] rd_data,
	input  logic [prtd_pkg::PIXEL_W-1:0] image_pixels,
	input  logic                         opaque_alpha,
	output logic                         take,
	output logic                         pixel_valid,
	input  logic                         pixel_ready,
	output prtd_pkg::out_item_t          pixel
);

	import prtd_pkg::*;

	logic [PIXEL_W-1:0] pixels_emitted_q;
	logic [PIXEL_W-1:0] size;
	logic [PIXEL_W-1:0] left;
	logic [PIXEL_W-1:0] run_w;
	logic [COLOR_W-1:0] color;
	logic               done;
	logic               load;

	assign take  = !pixel_valid || pixel_ready;
	assign load  = valid_s1 && take;
	assign color = ctl_s1.index_ok ? rd_data : '0;
	assign size  = (image_pixels == '0) ? PIXEL_W'(1) : image_pixels;
	assign left  = (pixels_emitted_q < size) ? size - pixels_emitted_q : PIXEL_W'(1);
	assign run_w = PIXEL_W'(ctl_s1.run);
	assign done  = (run_w >= left);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid      <= 1'b0;
			pixels_emitted_q <= '0;
		end else begin
			if (take) begin
				pixel_valid <= valid_s1;
			end
			if (load) begin
				pixels_emitted_q <= done ? '0 : pixels_emitted_q + run_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel.red        <= color[23:16];
			pixel.green      <= color[15:8];
			pixel.blue       <= color[7:0];
			pixel.alpha      <= opaque_alpha ? 8'hff : color[31:24];
			pixel.run_length <= done ? left[RUN_W-1:0] : ctl_s1.run;
			pixel.image_done <= done;
		end
	end

endmodule

// ----- sim/tb.sv -----
// tb: self-checking testbench for palette_rle_texture_decoder, directed table then random phases
// depends on prtd_pkg and the palette_rle_texture_decoder rtl; predicts each pixel run itself, fixed table rows apart

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import prtd_pkg::*;

	localparam int DEPTH       = PALETTE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int N_PHASES    = 6;
	localparam int PHASE_ITEMS = 100;
	localparam int SETTLE_CYC  = 6;   // a code byte's run passes stage one and then the result register

	// one row of the directed table; fixed rows carry a pixel typed in by hand
	typedef struct {
		in_item_t  it;
		bit        fixed;
		out_item_t px;
	} texture_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_ready;
	in_item_t               item;
	logic                   pixel_valid;
	logic                   pixel_ready;
	out_item_t              pixel;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [PIXEL_W-1:0]     cfg_data;

	// predictor state: scaled palette, armed run, pixel count and register copies
	logic [31:0]        pal_mem [DEPTH];
	bit                 pal_written [DEPTH];
	logic [7:0]         run_pending;
	bit                 run_is_armed;
	logic [PIXEL_W-1:0] pix_count;
	logic [PIXEL_W-1:0] cfg_image_pixels;
	bit                 cfg_opaque;

	out_item_t    pending_pixels [$];
	texture_row_t dir_rows [$];
	out_item_t    want_px;
	int           errors;
	int           cycle_count;
	int           sender_idle_pct;
	int           recv_stall_pct;

	// per-phase register settings and idling, filled in at the start of the run
	int ph_pixels [N_PHASES];
	bit ph_opaque [N_PHASES];
	int ph_send   [N_PHASES];
	int ph_recv   [N_PHASES];

	palette_rle_texture_decoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit roll(int pct);
		return $urandom_range(99) < pct;
	endfunction

	// rgb channel scaling by 255/256, truncated
	function automatic logic [7:0] scale8(logic [7:0] c);
		return 8'((16'(c) * 16'd255) >> 8);
	endfunction

	// advances the predictor by one accepted item; returns 1 when a pixel run is due
	function automatic bit decode_texture_item(input in_item_t it, output out_item_t px);
		logic [7:0]  b;
		logic [31:0] c;
		int          run;
		int          size;
		int          left;
		bit          done;
		b  = it.code_byte;
		px = '0;
		if (it.mode == MODE_PALETTE) begin
			if (int'(it.palette_slot) < DEPTH) begin
				pal_mem[it.palette_slot] = {it.palette_color[31:24],
					scale8(it.palette_color[23:16]), scale8(it.palette_color[15:8]),
					scale8(it.palette_color[7:0])};
				pal_written[it.palette_slot] = 1'b1;
			end
			return 1'b0;
		end
		// negative byte with nothing armed: arm a run, no output
		if (!run_is_armed && b[7]) begin
			run_pending  = 8'(9'd256 - {1'b0, b});
			run_is_armed = 1'b1;
			return 1'b0;
		end
		run          = run_is_armed ? int'(run_pending) + 1 : 1;
		run_is_armed = 1'b0;
		run_pending  = '0;
		// index past the palette, negative bytes under an armed run included, paints zero
		c    = (int'(b) < DEPTH) ? pal_mem[b[6:0]] : 32'h0;
		size = (cfg_image_pixels == 0) ? 1 : int'(cfg_image_pixels);
		// a count left above a lowered image size clamps to one pixel and ends the image
		left = (int'(pix_count) < size) ? size - int'(pix_count) : 1;
		if (run >= left) begin
			run       = left;
			done      = 1'b1;
			pix_count = '0;
		end else begin
			done      = 1'b0;
			pix_count = PIXEL_W'(int'(pix_count) + run);
		end
		px.red        = c[23:16];
		px.green      = c[15:8];
		px.blue       = c[7:0];
		px.alpha      = cfg_opaque ? 8'hFF : c[31:24];
		px.run_length = 8'(run);
		px.image_done = done;
		return 1'b1;
	endfunction

	// directed table helpers
	function automatic texture_row_t palette_row(logic [6:0] slot, logic [31:0] color);
		texture_row_t r;
		r.it.mode          = MODE_PALETTE;
		r.it.palette_slot  = slot;
		r.it.palette_color = color;
		r.it.code_byte     = 8'sh5A;
		r.fixed            = 1'b0;
		r.px               = '0;
		return r;
	endfunction

	function automatic texture_row_t code_row(logic signed [7:0] cb);
		texture_row_t r;
		r.it.mode          = MODE_CODE;
		r.it.palette_slot  = '0;
		r.it.palette_color = '0;
		r.it.code_byte     = cb;
		r.fixed            = 1'b0;
		r.px               = '0;
		return r;
	endfunction

	function automatic texture_row_t code_row_px(logic signed [7:0] cb, logic [7:0] red,
			logic [7:0] green, logic [7:0] blue, logic [7:0] alpha, logic [7:0] run,
			logic done);
		texture_row_t r;
		r                 = code_row(cb);
		r.fixed           = 1'b1;
		r.px.red          = red;
		r.px.green        = green;
		r.px.blue         = blue;
		r.px.alpha        = alpha;
		r.px.run_length   = run;
		r.px.image_done   = done;
		return r;
	endfunction

	// random item: mostly well-formed arm/index pairs, some palette writes and noise
	function automatic in_item_t next_texture_item();
		in_item_t it;
		int       slot;
		it.mode          = MODE_CODE;
		it.palette_slot  = 7'($urandom);
		it.palette_color = $urandom;
		it.code_byte     = 8'($urandom);
		if (roll(15)) begin
			it.mode = MODE_PALETTE;
		end else if (!run_is_armed && roll(35)) begin
			// short runs half the time so that images end at many offsets
			it.code_byte = 8'(256 - (roll(50) ? $urandom_range(1, 4) : $urandom_range(1, 128)));
		end else if (run_is_armed && roll(10)) begin
			// negative byte under an armed run reads past the palette
			it.code_byte = 8'($urandom_range(128, 255));
		end else begin
			// only written entries are ever read
			do slot = $urandom_range(DEPTH - 1); while (!pal_written[slot]);
			it.code_byte = 8'(slot);
		end
		return it;
	endfunction

	// sends one item; called just after a falling edge, returns just after one
	task automatic send_item(in_item_t it, bit fixed, out_item_t fixed_px);
		out_item_t px;
		while (roll(sender_idle_pct)) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		if (decode_texture_item(it, px))
			pending_pixels.push_back(fixed ? fixed_px : px);
		@(negedge clk);
	endtask

	// waits until every run has come out, plus the pipeline depth for silent items
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [PIXEL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_IMAGE_PIXELS)
			cfg_image_pixels = val;
		else
			cfg_opaque = val[0];
		@(negedge clk);
	endtask

	// both registers, only once the block has gone quiet
	task automatic configure(int pixels, bit opaque);
		settle();
		write_reg(REG_IMAGE_PIXELS, PIXEL_W'(pixels));
		write_reg(REG_OPAQUE_ALPHA, PIXEL_W'(opaque));
		cfg_valid <= 1'b0;
	endtask

	// receiver: ready redrawn every falling edge
	initial begin
		pixel_ready = 1'b0;
		forever begin
			@(negedge clk);
			pixel_ready <= !roll(recv_stall_pct);
		end
	end

	// every pixel transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && pixel_valid && pixel_ready) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t: pixel transaction with none expected, got %h", $time, pixel);
			end else begin
				want_px = pending_pixels.pop_front();
				if (pixel !== want_px) begin
					errors++;
					$display("%0t: pixel mismatch, expected r %h g %h b %h a %h run %0d done %b",
						$time, want_px.red, want_px.green, want_px.blue, want_px.alpha,
						want_px.run_length, want_px.image_done);
					$display("%0t:                   got r %h g %h b %h a %h run %0d done %b",
						$time, pixel.red, pixel.green, pixel.blue, pixel.alpha,
						pixel.run_length, pixel.image_done);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		// every input known from time zero
		arst_n          = 1'b0;
		item_valid      = 1'b0;
		item            = '0;
		cfg_valid       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		errors          = 0;
		cycle_count     = 0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		// predictor after reset: registers at their reset values, nothing armed
		run_pending      = '0;
		run_is_armed     = 1'b0;
		pix_count        = '0;
		cfg_image_pixels = PIXEL_W'(1);
		cfg_opaque       = 1'b0;
		foreach (pal_mem[i]) begin
			pal_mem[i]     = '0;
			pal_written[i] = 1'b0;
		end

		// phases: zero size, a size of 1048576, a small size below the carried-over count, a random
		// size, one pixel, a random size; idling none, sender, receiver, both, none, sender
		ph_pixels = '{0, 1048576, 7, $urandom_range(1, 400), 1, $urandom_range(1, 2000)};
		ph_opaque = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'($urandom)};
		ph_send   = '{0, 84, 0, 36, 0, 84};
		ph_recv   = '{0, 0, 84, 36, 0, 0};

		// directed table, image of 300 pixels, palette alpha passed through
		dir_rows.push_back(palette_row(7'd0, 32'hFFFF_FFFF));   // stored ff fe fe fe
		dir_rows.push_back(palette_row(7'd127, 32'h0000_0000));
		dir_rows.push_back(palette_row(7'd1, 32'h80FF_0080));   // stored 80 fe 00 7f
		dir_rows.push_back(code_row_px(8'sd0, 8'hFE, 8'hFE, 8'hFE, 8'hFF, 8'd1, 1'b0));
		dir_rows.push_back(code_row(-8'sd128));                 // longest run armed
		dir_rows.push_back(code_row_px(8'sd1, 8'hFE, 8'h00, 8'h7F, 8'h80, 8'd129, 1'b0));
		dir_rows.push_back(code_row(-8'sd1));
		dir_rows.push_back(palette_row(7'd2, 32'h1234_5678));   // write while armed keeps run
		dir_rows.push_back(code_row(8'sd2));
		dir_rows.push_back(code_row_px(8'sd127, 8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b0));
		dir_rows.push_back(code_row(-8'sd5));
		// negative byte under an armed run: index past the palette, colour zero
		dir_rows.push_back(code_row_px(-8'sd128, 8'h00, 8'h00, 8'h00, 8'h00, 8'd6, 1'b0));
		dir_rows.push_back(code_row(-8'sd1));
		dir_rows.push_back(code_row_px(-8'sd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'd2, 1'b0));
		dir_rows.push_back(code_row(-8'sd128));
		dir_rows.push_back(code_row_px(8'sd0, 8'hFE, 8'hFE, 8'hFE, 8'hFF, 8'd129, 1'b0));
		dir_rows.push_back(code_row(-8'sd128));
		// 30 pixels left: run clamped, image ends
		dir_rows.push_back(code_row_px(8'sd1, 8'hFE, 8'h00, 8'h7F, 8'h80, 8'd30, 1'b1));
		// next image starts from zero
		dir_rows.push_back(code_row_px(8'sd0, 8'hFE, 8'hFE, 8'hFE, 8'hFF, 8'd1, 1'b0));
		dir_rows.push_back(code_row(8'sd1));

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		configure(300, 1'b0);
		foreach (dir_rows[i])
			send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].px);

		// random phases, registers rewritten between them
		for (int ph = 0; ph < N_PHASES; ph++) begin
			configure(ph_pixels[ph], ph_opaque[ph]);
			sender_idle_pct = ph_send[ph];
			recv_stall_pct  = ph_recv[ph];
			repeat (PHASE_ITEMS) send_item(next_texture_item(), 1'b0, '0);
		end

		// drain and a few quiet cycles for anything stray
		settle();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/prtd_pkg.sv
sv/prtd_ram.sv
sv/prtd_front.sv
sv/prtd_back.sv
sv/palette_rle_texture_decoder.sv
sim/tb.sv
